>>> design/scf_pkg.sv
`timescale 1ns / 1ps

package scf_pkg;

    localparam int FreqWidth    = 11;
    localparam int SettingWidth = 7;
    localparam int CountWidth   = 4;

    localparam logic [2:0]            ShiftMask     = 3'h7;
    localparam int                    NegateBit     = 3;
    localparam logic [CountWidth-1:0] DefaultPeriod = 4'd8;

    typedef enum logic [1:0] {
        OP_WRITE_SETTING = 2'd0,
        OP_TRIGGER       = 2'd1,
        OP_SWEEP_TICK    = 2'd2,
        OP_DISARM        = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [SettingWidth-1:0] setting;
        logic [FreqWidth-1:0]    shadow;
        logic                    negate_used;
        logic                    armed;
        logic [CountWidth-1:0]   countdown;
    } sweep_state_t;

    typedef struct packed {
        logic                 frequency_update;
        logic [FreqWidth-1:0] new_frequency;
        logic                 disable_channel;
    } sweep_result_t;

    // shadow +/- (shadow >> shift); bit FreqWidth is the overflow flag
    function automatic logic [FreqWidth:0] sweep_calc(
        input logic [FreqWidth-1:0]    freq,
        input logic [SettingWidth-1:0] setting
    );
        logic [FreqWidth-1:0] delta;
        delta = freq >> (setting[2:0] & ShiftMask);
        if (setting[NegateBit])
        begin
            sweep_calc = {1'b0, freq} - {1'b0, delta};
        end
        else
        begin
            sweep_calc = {1'b0, freq} + {1'b0, delta};
        end
    endfunction

endpackage

>>> design/scf_step.sv
`timescale 1ns / 1ps

module scf_step
    import scf_pkg::*;
(
    input  sweep_state_t                cur,
    input  logic [1:0]                  opcode,
    input  logic [SettingWidth-1:0]     setting_value,
    input  logic [FreqWidth-1:0]        trigger_frequency,
    output sweep_state_t                nxt,
    output sweep_result_t               res
);

    logic [2:0]           period;
    logic [2:0]           shift;
    logic [FreqWidth:0]   calc_first;
    logic [FreqWidth:0]   calc_second;
    logic [FreqWidth-1:0] calc_src;

    assign period = cur.setting[6:4];
    assign shift  = cur.setting[2:0] & ShiftMask;

    // trigger checks the incoming frequency, a tick checks the shadow
    assign calc_src    = (opcode_t'(opcode) == OP_TRIGGER) ? trigger_frequency : cur.shadow;
    assign calc_first  = sweep_calc(calc_src, cur.setting);
    assign calc_second = sweep_calc(calc_first[FreqWidth-1:0], cur.setting);

    always_comb
    begin
        nxt = cur;
        res = '0;
        case (opcode_t'(opcode))
            OP_WRITE_SETTING:
            begin
                res.disable_channel = cur.negate_used && !setting_value[NegateBit];
                nxt.setting         = setting_value;
            end
            OP_TRIGGER:
            begin
                nxt.negate_used = 1'b0;
                nxt.shadow      = trigger_frequency;
                if ((period | shift) != 3'd0)
                begin
                    nxt.armed     = 1'b1;
                    nxt.countdown = (period != 3'd0) ? {1'b0, period} : DefaultPeriod;
                end
                else
                begin
                    nxt.armed     = 1'b0;
                    nxt.countdown = '0;
                end
                if (shift != 3'd0)
                begin
                    nxt.negate_used     = cur.setting[NegateBit];
                    res.disable_channel = calc_first[FreqWidth];
                end
            end
            OP_SWEEP_TICK:
            begin
                if (cur.armed)
                begin
                    if (cur.countdown > 4'd1)
                    begin
                        nxt.countdown = cur.countdown - 4'd1;
                    end
                    else
                    begin
                        if (period != 3'd0)
                        begin
                            nxt.negate_used     = cur.negate_used | cur.setting[NegateBit];
                            res.disable_channel = calc_first[FreqWidth];
                            if (!calc_first[FreqWidth] && (shift != 3'd0))
                            begin
                                nxt.shadow           = calc_first[FreqWidth-1:0];
                                res.frequency_update = 1'b1;
                                res.new_frequency    = calc_first[FreqWidth-1:0];
                                res.disable_channel  = calc_second[FreqWidth];
                            end
                        end
                        nxt.countdown = (period != 3'd0) ? {1'b0, period} : DefaultPeriod;
                    end
                end
            end
            OP_DISARM:
            begin
                nxt.armed = 1'b0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

>>> design/square_channel_frequency_sweep_unit.sv
`timescale 1ns / 1ps

// frequency sweep unit of a square-wave sound channel
// input channel (in_valid / in_ready): one transaction carries an opcode
//   (write sweep setting, trigger, sweep tick, disarm) with setting_value and
//   trigger_frequency; fields that the opcode does not use are ignored
// output channel (out_valid / out_ready): exactly one result transaction per
//   input transaction, in order: frequency_update, new_frequency and
//   disable_channel
// an accepted transaction lands in the input register, passes the step
//   logic and is written into the result register when that slot is free
//   or being emptied, and is shown from then on
// throughput: one transaction per cycle unless the output stalls; the whole
//   step (two chained shift-add overflow checks) lies between the registers
// a stalled receiver holds the result register; the input register still
//   takes one more transaction, after which in_ready drops until the result
//   is taken
// reset (rst_n low, asynchronous) empties both registers and clears the sweep
//   setting, shadow frequency, negate-used flag and countdown

module square_channel_frequency_sweep_unit
    import scf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic [SettingWidth-1:0] setting_value,
    input  logic [FreqWidth-1:0]    trigger_frequency,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    frequency_update,
    output logic [FreqWidth-1:0]    new_frequency,
    output logic                    disable_channel
);

    // input register
    logic                    in_valid_reg;
    logic [1:0]              opcode_reg;
    logic [SettingWidth-1:0] setting_reg;
    logic [FreqWidth-1:0]    trig_reg;

    // result register
    logic                    out_valid_reg;
    sweep_result_t           result_reg;

    // sweep state
    sweep_state_t            state_reg;
    sweep_state_t            state_next;
    sweep_result_t           result_next;

    logic                    advance;
    logic                    fire;

    // result slot free or being emptied this cycle
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    scf_step u_step (
        .cur               (state_reg),
        .opcode            (opcode_reg),
        .setting_value     (setting_reg),
        .trigger_frequency (trig_reg),
        .nxt               (state_next),
        .res               (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // state moves only when the step's result is committed
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg  <= opcode;
            setting_reg <= setting_value;
            trig_reg    <= trigger_frequency;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign frequency_update = result_reg.frequency_update;
    assign new_frequency    = result_reg.new_frequency;
    assign disable_channel  = result_reg.disable_channel;

endmodule

>>> design/scf_checker.sv
`timescale 1ns / 1ps

module scf_checker
    import scf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 frequency_update,
    input logic [FreqWidth-1:0] new_frequency,
    input logic                 disable_channel
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frequency_update)
            && $stable(new_frequency) && $stable(disable_channel))
        else $error("stalled result changed");

    // no written-back frequency means a zero frequency field
    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frequency_update |-> new_frequency == '0)
        else $error("new_frequency nonzero without update");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while result register empty");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind square_channel_frequency_sweep_unit scf_checker u_scf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .frequency_update (frequency_update),
    .new_frequency    (new_frequency),
    .disable_channel  (disable_channel)
);
